// ----- rtl/core/ddf_pkg.sv -----
// Shared types and constants for the decimal digit formatter.
`default_nettype none

package ddf_pkg;

   localparam int unsigned DEF_MAX_DIGITS   = 10;
   localparam int unsigned DEF_NUMBER_WIDTH = 32;

   localparam logic [7:0] GLYPH_HEIGHT_RESET = 8'd16;

   localparam logic [5:0] CODE_SPACE = 6'd32;
   localparam logic [5:0] CODE_ZERO  = 6'd48;
   localparam logic [5:0] CODE_NINE  = 6'd57;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } ddf_state_type;

   // control from the sequencer to the digit chain
   typedef struct packed {
      logic load;
      logic shift;
   } ddf_chain_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/core/ddf_req_if.sv -----
// Input channel: number to format, digit count, start column and page row.
`default_nettype none

interface ddf_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] number;
   logic [3:0]  digit_count;
   logic [7:0]  start_column;
   logic [2:0]  page_row;

   modport source (output valid, number, digit_count, start_column, page_row,
                   input ready);
   modport sink   (input valid, number, digit_count, start_column, page_row,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ddf_rsp_if.sv -----
// Result channel: one character with its column, row and last flag.
`default_nettype none

interface ddf_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] char_code;
   logic [7:0] column;
   logic [2:0] row;
   logic       last;

   modport source (output valid, char_code, column, row, last, input ready);
   modport sink   (input valid, char_code, column, row, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ddf_bcd_cell.sv -----
// One BCD digit cell of the shift-and-add-3 chain.
`default_nettype none

module ddf_bcd_cell (
   input  wire logic                        clock,
   input  wire ddf_pkg::ddf_chain_ctrl_type ctrl,
   input  wire logic                        carry_in,
   output logic                             carry_out,
   output logic [3:0]                       digit
);
   import ddf_pkg::*;

   logic [3:0] digit_ff;
   logic [3:0] digit_in;
   logic [3:0] adj;

   // add 3 when the digit would overflow past 9 after doubling
   always_comb begin
      adj = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   end

   always_comb begin
      if (ctrl.load) begin
         digit_in = 4'd0;
      end else if (ctrl.shift) begin
         digit_in = {adj[2:0], carry_in};
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign carry_out = adj[3];
   assign digit     = digit_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ddf_bcd_chain.sv -----
// Binary shift register feeding a row of BCD digit cells.
`default_nettype none

module ddf_bcd_chain #(
   parameter int unsigned MAX_DIGITS   = ddf_pkg::DEF_MAX_DIGITS,
   parameter int unsigned NUMBER_WIDTH = ddf_pkg::DEF_NUMBER_WIDTH
) (
   input  wire logic                          clock,
   input  wire ddf_pkg::ddf_chain_ctrl_type   ctrl,
   input  wire logic [NUMBER_WIDTH-1:0]       number,
   output logic [MAX_DIGITS-1:0][3:0]         digits
);
   import ddf_pkg::*;

   logic [NUMBER_WIDTH-1:0] num_ff;
   logic [NUMBER_WIDTH-1:0] num_in;
   logic [MAX_DIGITS-1:0]   carry;

   always_comb begin
      if (ctrl.load) begin
         num_in = number;
      end else if (ctrl.shift) begin
         num_in = {num_ff[NUMBER_WIDTH-2:0], 1'b0};
      end else begin
         num_in = num_ff;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
   end

   // msb first into the lowest digit
   assign carry[0] = num_ff[NUMBER_WIDTH-1];

   // carry out of the top digit is dropped: value is kept modulo 10^MAX_DIGITS
   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      if (i == MAX_DIGITS - 1) begin : g_top
         ddf_bcd_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .carry_in  (carry[i]),
            .carry_out (),
            .digit     (digits[i])
         );
      end else begin : g_mid
         ddf_bcd_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .carry_in  (carry[i]),
            .carry_out (carry[i+1]),
            .digit     (digits[i])
         );
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/decimal_digit_formatter_unit.sv -----
// Top level of the decimal digit formatter with leading-zero blanking.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  req_chan| in  | valid/ready        | number, digit_count, start_column, page_row
//  rsp_chan| out | valid/ready        | char_code, column, row, last
//  csr_*   | in  | write enable only  | glyph_height (8 bits)
//
// An item is accepted, shifted bit by bit through the BCD cells, then emitted
// as one character per cycle while rsp_chan does not stall it; a zero count
// emits nothing.
// Reset is synchronous, active high: clears the sequencer and output valid and
// sets glyph_height to 16. A stalled rsp_chan holds the current character; the
// next item is taken once the last character sits in the output register.
`default_nettype none

module decimal_digit_formatter_unit #(
   parameter int unsigned MAX_DIGITS   = ddf_pkg::DEF_MAX_DIGITS,
   parameter int unsigned NUMBER_WIDTH = ddf_pkg::DEF_NUMBER_WIDTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   ddf_req_if.sink         req_chan,
   ddf_rsp_if.source       rsp_chan,
   input  wire logic       csr_write_enable,
   input  wire logic [7:0] csr_write_data
);
   import ddf_pkg::*;

   localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int unsigned BIT_W = $clog2(NUMBER_WIDTH);

   // configuration
   logic [7:0] glyph_height_ff;

   // sequencer
   ddf_state_type state_ff, state_in;
   logic [BIT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [IDX_W-1:0] exp_ff, exp_in;      // digit index being emitted
   logic             none_ff, none_in;    // clamped count was zero
   logic             shown_ff, shown_in;  // a nonzero digit already emitted
   logic [7:0]       col_ff, col_in;
   logic [6:0]       step_ff, step_in;
   logic [2:0]       row_ff, row_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [5:0] rsp_code_ff, rsp_code_in;
   logic [7:0] rsp_col_ff, rsp_col_in;
   logic [2:0] rsp_row_ff, rsp_row_in;
   logic       rsp_last_ff, rsp_last_in;

   ddf_chain_ctrl_type          chain_ctrl;
   logic [MAX_DIGITS-1:0][3:0]  digits;
   logic                        req_fire;
   logic                        emit_fire;
   logic                        out_free;
   logic [3:0]                  count_clamped;
   logic [3:0]                  digit_sel;
   logic                        final_pos;
   logic                        blank;

   ddf_bcd_chain #(
      .MAX_DIGITS   (MAX_DIGITS),
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_chain (
      .clock  (clock),
      .ctrl   (chain_ctrl),
      .number (req_chan.number[NUMBER_WIDTH-1:0]),
      .digits (digits)
   );

   // clamp count to the chain length
   always_comb begin
      if (32'(req_chan.digit_count) > MAX_DIGITS) begin
         count_clamped = 4'(MAX_DIGITS);
      end else begin
         count_clamped = req_chan.digit_count;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign digit_sel = digits[exp_ff];
   assign final_pos = (exp_ff == '0);
   assign blank     = !shown_ff && !final_pos && (digit_sel == 4'd0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (bit_cnt_ff == '0) begin
               state_in = none_ff ? ST_IDLE : ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && final_pos) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_chan.ready   = 1'b0;
      chain_ctrl.load  = 1'b0;
      chain_ctrl.shift = 1'b0;
      emit_fire        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready  = 1'b1;
            chain_ctrl.load = req_chan.valid;
         end
         ST_CONVERT: begin
            chain_ctrl.shift = 1'b1;
         end
         ST_EMIT: begin
            emit_fire = out_free;
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
   end

   // item context and per-character bookkeeping
   always_comb begin
      bit_cnt_in = bit_cnt_ff;
      exp_in     = exp_ff;
      none_in    = none_ff;
      shown_in   = shown_ff;
      col_in     = col_ff;
      step_in    = step_ff;
      row_in     = row_ff;
      if (req_fire) begin
         bit_cnt_in = BIT_W'(NUMBER_WIDTH - 1);
         exp_in     = IDX_W'(count_clamped - 4'd1);
         none_in    = (count_clamped == 4'd0);
         shown_in   = 1'b0;
         col_in     = req_chan.start_column;
         step_in    = glyph_height_ff[7:1];
         row_in     = req_chan.page_row;
      end else if (chain_ctrl.shift) begin
         bit_cnt_in = bit_cnt_ff - BIT_W'(1);
      end else if (emit_fire) begin
         exp_in   = exp_ff - IDX_W'(1);
         shown_in = shown_ff || !blank;
         col_in   = col_ff + {1'b0, step_ff};
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_code_in  = rsp_code_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = blank ? CODE_SPACE : (CODE_ZERO + {2'b00, digit_sel});
         rsp_col_in   = col_ff;
         rsp_row_in   = row_ff;
         rsp_last_in  = final_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         glyph_height_ff <= GLYPH_HEIGHT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            glyph_height_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      bit_cnt_ff  <= bit_cnt_in;
      exp_ff      <= exp_in;
      none_ff     <= none_in;
      shown_ff    <= shown_in;
      col_ff      <= col_in;
      step_ff     <= step_in;
      row_ff      <= row_in;
      rsp_code_ff <= rsp_code_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.char_code = rsp_code_ff;
   assign rsp_chan.column    = rsp_col_ff;
   assign rsp_chan.row       = rsp_row_ff;
   assign rsp_chan.last      = rsp_last_ff;

`ifndef SYNTHESIS
   a_accept_starts_convert : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_CONVERT)
      else $error("accepted item did not start conversion");

   a_last_ends_item : assert property (@(posedge clock) disable iff (reset)
      emit_fire && final_pos |=> state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff)
      else $error("final character did not close the item");

   a_code_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_code_ff == CODE_SPACE
                       || (rsp_code_ff >= CODE_ZERO && rsp_code_ff <= CODE_NINE))
      else $error("character code out of range");

   a_last_is_digit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_code_ff != CODE_SPACE)
      else $error("final character blanked");

   a_no_emit_on_pending : assert property (@(posedge clock) disable iff (reset)
      emit_fire |-> !rsp_valid_ff || rsp_chan.ready)
      else $error("character overwrote a pending result");
`endif

endmodule

`default_nettype wire

// ----- tb/ddf_digit_checker.sv -----
// Scoreboard for the decimal digit formatter: predicts each character and compares.
module ddf_digit_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   ddf_req_if              req_chan,
   ddf_rsp_if              rsp_chan,
   input  wire logic       csr_write_enable,
   input  wire logic [7:0] csr_write_data,
   output int unsigned     glyphs_pending,
   output int unsigned     error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import ddf_pkg::*;

   typedef struct packed {
      logic [5:0] char_code;
      logic [7:0] column;
      logic [2:0] row;
      logic       last;
   } glyph_type;

   glyph_type  expected_glyphs[$];
   logic [7:0] glyph_height;

   initial begin
      error_count    = 0;
      glyphs_pending = 0;
      glyph_height   = GLYPH_HEIGHT_RESET;
   end

   task automatic report_fault(input string what, input int unsigned got,
                               input int unsigned want);
      $display("[%0t] ERROR digit check: %s got %0d, want %0d", $time, what, got, want);
      error_count++;
   endtask

   // Expected characters for one number, most significant position first.
   function automatic void format_number(input logic [31:0] number,
                                         input logic [3:0]  count_in,
                                         input logic [7:0]  start,
                                         input logic [2:0]  row);
      logic [3:0]  digits [10];
      logic [31:0] rest;
      logic [7:0]  step;
      logic        shown;
      int unsigned count;
      int unsigned i;
      int unsigned pos;
      glyph_type   g;
      rest = number;
      for (i = 0; i < 10; i++) begin
         digits[i] = 4'(rest % 10);
         rest      = rest / 10;
      end
      count = (count_in > DEF_MAX_DIGITS) ? DEF_MAX_DIGITS : count_in;
      step  = glyph_height >> 1;
      shown = 1'b0;
      for (pos = 0; pos < count; pos++) begin
         g.last = (pos == count - 1);
         if (!shown && !g.last && digits[count - 1 - pos] == 4'd0) begin
            g.char_code = CODE_SPACE;
         end else begin
            shown       = 1'b1;
            g.char_code = CODE_ZERO + 6'(digits[count - 1 - pos]);
         end
         g.column = start + 8'(step * pos);
         g.row    = row;
         expected_glyphs.push_back(g);
      end
   endfunction

   always @(posedge clock) begin : watch
      glyph_type want;
      if (reset) begin
         glyph_height = GLYPH_HEIGHT_RESET;
         expected_glyphs.delete();
      end else begin
         if (csr_write_enable) begin
            glyph_height = csr_write_data;
         end
         if (req_chan.valid && req_chan.ready) begin
            format_number(req_chan.number, req_chan.digit_count,
                          req_chan.start_column, req_chan.page_row);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_glyphs.size() == 0) begin
               report_fault("unexpected char_code", 32'(rsp_chan.char_code), 0);
            end else begin
               want = expected_glyphs.pop_front();
               if (rsp_chan.char_code !== want.char_code)
                  report_fault("char_code", 32'(rsp_chan.char_code),
                               32'(want.char_code));
               if (rsp_chan.column !== want.column)
                  report_fault("column", 32'(rsp_chan.column), 32'(want.column));
               if (rsp_chan.row !== want.row)
                  report_fault("row", 32'(rsp_chan.row), 32'(want.row));
               if (rsp_chan.last !== want.last)
                  report_fault("last", 32'(rsp_chan.last), 32'(want.last));
            end
         end
      end
      glyphs_pending = expected_glyphs.size();
   end

endmodule

// ----- tb/decimal_digit_formatter_unit_tb.sv -----
// Testbench top for the decimal digit formatter: stimulus, stalls and verdict.
module decimal_digit_formatter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ddf_pkg::*;

   // conversion, the accept and up to ten characters, plus margin
   localparam int unsigned SETTLE_CYCLES = 64;
   // covers the slowest item; a couple of hundred items and the settles
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SIZE_PHASES   = 7;
   localparam int unsigned PHASE_ITEMS   = 21;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [7:0]  csr_write_data;
   logic        no_gaps;         // set for one phase: both sides run flat out
   int unsigned drain_wait;
   int unsigned cycle_count = 0;
   int unsigned glyphs_pending;
   int unsigned error_count;

   ddf_req_if req_chan ();
   ddf_rsp_if rsp_chan ();

   decimal_digit_formatter_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   ddf_digit_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .glyphs_pending   (glyphs_pending),
      .error_count      (error_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Result side back-pressure. After each accepted character ready may drop;
   // now and then it also drops while nothing is offered, so the first
   // character of an item gets stalled as well.
   always @(posedge clock) begin : rsp_stall
      int unsigned wait_n;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         drain_wait     <= 0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         wait_n = no_gaps ? 0 : $urandom_range(0, 4);
         drain_wait     <= wait_n;
         rsp_chan.ready <= (wait_n == 0);
      end else if (!rsp_chan.ready) begin
         if (drain_wait <= 1) begin
            rsp_chan.ready <= 1'b1;
            drain_wait     <= 0;
         end else begin
            drain_wait <= drain_wait - 1;
         end
      end else if (!no_gaps && $urandom_range(0, 15) == 0) begin
         rsp_chan.ready <= 1'b0;
         drain_wait     <= $urandom_range(1, 4);
      end
   end

   // Offer one item after a random gap and return on the edge that takes it.
   // valid is left high so a back-to-back item needs no second assignment.
   task automatic send_digits(input logic [31:0] number, input logic [3:0] count,
                              input logic [7:0] start, input logic [2:0] row);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.number       <= number;
      req_chan.digit_count  <= count;
      req_chan.start_column <= start;
      req_chan.page_row     <= row;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Stop offering and wait until every predicted character has come back.
   // A count of zero yields no characters, so a register write also waits out
   // a full conversion afterwards.
   task automatic hold_until_drained(input bit with_settle);
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (glyphs_pending != 0);
      if (with_settle) begin
         repeat (SETTLE_CYCLES) @(posedge clock);
      end else begin
         @(posedge clock);
      end
   endtask

   task automatic set_glyph_height(input logic [7:0] size);
      csr_write_enable <= 1'b1;
      csr_write_data   <= size;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Numbers that stress blanking: tiny values, round powers of ten, runs of
   // nines, the top of the range and plain random words.
   function automatic logic [31:0] pick_number();
      logic [31:0] tens;
      tens = 1;
      repeat ($urandom_range(0, 9)) tens = tens * 10;
      case ($urandom_range(0, 6))
         0:       return $urandom_range(0, 9);
         1:       return $urandom_range(0, 99999);
         2:       return tens * $urandom_range(1, 4);
         3:       return tens - 1;
         4:       return tens + $urandom_range(1, 9);
         5:       return 32'hFFFF_FFFF - $urandom_range(0, 999);
         default: return $urandom();
      endcase
   endfunction

   // Mostly legal counts; a few zero counts and a few above the clamp.
   function automatic logic [3:0] pick_count();
      int unsigned k;
      k = $urandom_range(0, 19);
      if (k == 0) return 4'd0;
      if (k <= 2) return 4'($urandom_range(11, 15));
      return 4'($urandom_range(1, 10));
   endfunction

   initial begin : stimulus
      int unsigned phase;
      int unsigned n;
      logic [7:0]  size;
      reset                 = 1'b1;
      no_gaps               = 1'b0;
      csr_write_enable      = 1'b0;
      csr_write_data        = 8'd0;
      req_chan.valid        = 1'b0;
      req_chan.number       = 32'd0;
      req_chan.digit_count  = 4'd0;
      req_chan.start_column = 8'd0;
      req_chan.page_row     = 3'd0;
      rsp_chan.ready        = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed items at the reset glyph size (column step 8).
      send_digits(32'd0,          4'd1,  8'd0,   3'd0);  // lone zero still shown
      send_digits(32'd0,          4'd10, 8'd0,   3'd7);  // nine blanks then zero
      send_digits(32'hFFFF_FFFF,  4'd10, 8'd255, 3'd7);  // full range, column wraps
      send_digits(32'hFFFF_FFFF,  4'd15, 8'd3,   3'd2);  // count clamped to ten
      send_digits(32'd1234567890, 4'd11, 8'd100, 3'd3);  // just over the clamp
      send_digits(32'd1234567890, 4'd4,  8'd0,   3'd1);  // high digits cut off
      send_digits(32'd1000000000, 4'd10, 8'd9,   3'd4);
      send_digits(32'd1000000000, 4'd9,  8'd9,   3'd4);  // remainder is zero
      send_digits(32'd100,        4'd5,  8'd250, 3'd2);  // blanks then wrap
      send_digits(32'd907,        4'd3,  8'd40,  3'd6);  // inner zero kept
      send_digits(32'd5,          4'd0,  8'd17,  3'd5);  // count zero: nothing out
      send_digits(32'd0,          4'd0,  8'd255, 3'd7);
      send_digits(32'd9,          4'd1,  8'd1,   3'd1);
      send_digits(32'h8000_0000,  4'd10, 8'd128, 3'd0);
      send_digits(32'd10,         4'd2,  8'd64,  3'd3);
      send_digits(32'd10,         4'd1,  8'd64,  3'd3);  // shows only the zero
      send_digits(32'd99999,      4'd8,  8'd200, 3'd5);
      send_digits(32'd42,         4'd14, 8'd128, 3'd5);
      send_digits(32'd7,          4'd12, 8'd0,   3'd0);
      send_digits(32'd0,          4'd15, 8'd255, 3'd7);
      send_digits(32'd3000000001, 4'd10, 8'd77,  3'd6);

      // Random phases, each with its own glyph size, the extremes among them.
      for (phase = 0; phase < SIZE_PHASES; phase++) begin
         hold_until_drained(1'b1);
         case (phase)
            0:       size = 8'd255;
            1:       size = 8'd0;
            2:       size = 8'd1;
            6:       size = GLYPH_HEIGHT_RESET;
            default: size = 8'($urandom());
         endcase
         set_glyph_height(size);
         no_gaps <= (phase == 3);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 24) == 0) hold_until_drained(1'b0);
            send_digits(pick_number(), pick_count(), 8'($urandom_range(0, 255)),
                        3'($urandom_range(0, 7)));
         end
      end

      hold_until_drained(1'b1);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/ddf_pkg.sv
rtl/core/ddf_req_if.sv
rtl/core/ddf_rsp_if.sv
rtl/core/ddf_bcd_cell.sv
rtl/core/ddf_bcd_chain.sv
rtl/core/decimal_digit_formatter_unit.sv
tb/ddf_digit_checker.sv
tb/decimal_digit_formatter_unit_tb.sv
